// ===== rtl/gcp_pkg.sv =====
// Shared types and constants of the glyph cell painter.
// No dependencies; the other files that use it refer to it by scoped names.
`default_nettype none
package gcp_pkg;

  localparam int GLYPH_COUNT_DEF = 128;
  localparam int GLYPH_LINES_DEF = 15;
  localparam int MAX_WRITES      = 15;

  localparam logic [7:0] FIRST_CODE = 8'd32;

  localparam int OFFSET_W    = 24;
  localparam int DATA_W      = 64;
  localparam int WIDTH_W     = 14;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 14;

  localparam logic [CFG_INDEX_W-1:0] REG_MONO_MODE      = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_SCANLINE_WIDTH = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_REVERSE_VIDEO  = 2'd2;

  localparam logic [WIDTH_W-1:0] SCANLINE_WIDTH_RESET = 14'd1024;

  typedef struct packed {
    logic capture;
    logic setup;
    logic advance;
  } ctrl_cmd_t;

  typedef struct packed {
    logic is_paint;
    logic last_line;
  } dp_status_t;

endpackage
`default_nettype wire

// ===== rtl/gcp_item_if.sv =====
// Input item channel: valid/ready handshake with load and paint fields.
// Does not depend on gcp_pkg.
`default_nettype none
interface gcp_item_if;
  logic       valid;
  logic       ready;
  logic       mode;
  logic [7:0] char_code;
  logic [3:0] glyph_line;
  logic [7:0] glyph_bits;
  logic [6:0] text_row;
  logic [7:0] text_col;

  modport source(output valid, mode, char_code, glyph_line, glyph_bits, text_row, text_col,
                 input ready);
  modport sink(input valid, mode, char_code, glyph_line, glyph_bits, text_row, text_col,
               output ready);
endinterface
`default_nettype wire

// ===== rtl/gcp_write_if.sv =====
// Framebuffer write channel: valid/ready handshake with offset, data and flags.
// Widths come from gcp_pkg.
`default_nettype none
interface gcp_write_if;
  logic                          valid;
  logic                          ready;
  logic [gcp_pkg::OFFSET_W-1:0]  write_offset;
  logic [gcp_pkg::DATA_W-1:0]    write_data;
  logic                          wide_write;
  logic                          last_write;

  modport source(output valid, write_offset, write_data, wide_write, last_write,
                 input ready);
  modport sink(input valid, write_offset, write_data, wide_write, last_write,
               output ready);
endinterface
`default_nettype wire

// ===== rtl/gcp_cfg_if.sv =====
// Configuration write channel: valid/ready handshake with register index and data.
// Widths come from gcp_pkg.
`default_nettype none
interface gcp_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [gcp_pkg::CFG_INDEX_W-1:0] index;
  logic [gcp_pkg::CFG_DATA_W-1:0]  data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== rtl/gcp_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module gcp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1920,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

// ===== rtl/gcp_ctrl.sv =====
// Controller of the glyph cell painter: sequences capture, setup and emission.
// Depends on gcp_pkg for the command and status structs.
`default_nettype none
module gcp_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  output logic                     out_valid,
  input  wire logic                out_ready,
  input  wire gcp_pkg::dp_status_t status,
  output gcp_pkg::ctrl_cmd_t       cmd
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SETUP = 2'd1;
  localparam logic [1:0] ST_EMIT  = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       out_valid_next;
  logic       out_free;

  assign in_ready = (state == ST_IDLE);
  assign out_free = !out_valid || out_ready;

  always_comb begin
    state_next  = state;
    cmd         = '0;
    cmd.capture = in_valid && (state == ST_IDLE);
    case (state)
      ST_IDLE: begin
        if (in_valid && status.is_paint) begin
          state_next = ST_SETUP;
        end
      end
      ST_SETUP: begin
        cmd.setup  = 1'b1;
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          cmd.advance = 1'b1;
          if (status.last_line) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_next = out_valid;
    if (cmd.advance) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

`ifndef SYNTHESIS
  a_advance_free: assert property (@(posedge clk) disable iff (rst)
    cmd.advance |-> (!out_valid || out_ready))
    else $error("beat loaded over a pending write");

  a_paint_setup: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && status.is_paint) |=> (state == ST_SETUP))
    else $error("paint beat did not start setup");

  a_setup_emit: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SETUP) |=> (state == ST_EMIT && !in_ready))
    else $error("setup did not lead to emission");

  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    (cmd.advance && status.last_line) |=> (state == ST_IDLE && out_valid))
    else $error("last write did not end the character");
`endif

endmodule
`default_nettype wire

// ===== rtl/gcp_dp.sv =====
// Datapath of the glyph cell painter: registers, font store, offset and data build.
// Depends on gcp_pkg and gcp_ram.
`default_nettype none
module gcp_dp #(
  parameter int GLYPH_COUNT = gcp_pkg::GLYPH_COUNT_DEF,
  parameter int GLYPH_LINES = gcp_pkg::GLYPH_LINES_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire gcp_pkg::ctrl_cmd_t                cmd,
  output gcp_pkg::dp_status_t                    status,
  input  wire logic                              item_mode,
  input  wire logic [7:0]                        item_char_code,
  input  wire logic [3:0]                        item_glyph_line,
  input  wire logic [7:0]                        item_glyph_bits,
  input  wire logic [6:0]                        item_text_row,
  input  wire logic [7:0]                        item_text_col,
  input  wire logic                              cfg_write,
  input  wire logic [gcp_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  wire logic [gcp_pkg::CFG_DATA_W-1:0]    cfg_data,
  output logic      [gcp_pkg::OFFSET_W-1:0]      write_offset,
  output logic      [gcp_pkg::DATA_W-1:0]        write_data,
  output logic                                   wide_write,
  output logic                                   last_write
);

  localparam int DEPTH      = GLYPH_COUNT * GLYPH_LINES;
  localparam int AW         = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int LINE_COUNT = (GLYPH_LINES < gcp_pkg::MAX_WRITES) ? GLYPH_LINES
                                                                  : gcp_pkg::MAX_WRITES;
  localparam int LINE_W     = (LINE_COUNT > 1) ? $clog2(LINE_COUNT) : 1;
  localparam int RL_W       = 7 + $clog2(GLYPH_LINES + 1);
  localparam logic [LINE_W-1:0] LAST_LINE = LINE_W'(LINE_COUNT - 1);

  logic                         mono_mode;
  logic [gcp_pkg::WIDTH_W-1:0]  scanline_width;
  logic                         reverse_video;

  logic [7:0]                   glyph_idx;
  logic                         in_store;
  logic                         load_ok;
  logic [AW-1:0]                item_addr;

  logic                         in_store_q;
  logic                         space_q;
  logic [7:0]                   col_q;
  logic [RL_W-1:0]              row_lines_q;
  logic [AW-1:0]                base_addr_q;
  logic [gcp_pkg::OFFSET_W-1:0] offset_q;
  logic [LINE_W-1:0]            line_cnt;

  logic [gcp_pkg::WIDTH_W-1:0]  stride;
  logic [10:0]                  start;
  logic                         rd_en;
  logic [AW-1:0]                rd_addr;
  logic [7:0]                   rd_data;
  logic [7:0]                   glyph;
  logic [gcp_pkg::DATA_W-1:0]   spread;

  assign glyph_idx = item_char_code - gcp_pkg::FIRST_CODE;
  assign in_store  = (item_char_code >= gcp_pkg::FIRST_CODE) && (32'(glyph_idx) < GLYPH_COUNT);
  assign load_ok   = in_store && (32'(item_glyph_line) < GLYPH_LINES);
  assign item_addr = AW'(32'(glyph_idx) * GLYPH_LINES);

  always_ff @(posedge clk) begin
    if (rst) begin
      mono_mode      <= 1'b1;
      scanline_width <= gcp_pkg::SCANLINE_WIDTH_RESET;
      reverse_video  <= 1'b0;
    end else if (cfg_write) begin
      case (cfg_index)
        gcp_pkg::REG_MONO_MODE:      mono_mode      <= cfg_data[0];
        gcp_pkg::REG_SCANLINE_WIDTH: scanline_width <= cfg_data[gcp_pkg::WIDTH_W-1:0];
        gcp_pkg::REG_REVERSE_VIDEO:  reverse_video  <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  assign stride = mono_mode ? (scanline_width >> 3) : scanline_width;
  assign start  = mono_mode ? {3'b000, col_q} : {col_q, 3'b000};

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      in_store_q  <= in_store;
      space_q     <= (item_char_code == gcp_pkg::FIRST_CODE);
      col_q       <= item_text_col;
      row_lines_q <= RL_W'(32'(item_text_row) * GLYPH_LINES);
      base_addr_q <= in_store ? item_addr : '0;
    end
    if (cmd.setup) begin
      offset_q <= gcp_pkg::OFFSET_W'(start)
                + gcp_pkg::OFFSET_W'(row_lines_q) * gcp_pkg::OFFSET_W'(stride);
    end else if (cmd.advance) begin
      offset_q <= offset_q + gcp_pkg::OFFSET_W'(stride);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_cnt <= '0;
    end else if (cmd.setup) begin
      line_cnt <= '0;
    end else if (cmd.advance) begin
      line_cnt <= line_cnt + 1'b1;
    end
  end

  assign rd_en   = cmd.setup || (cmd.advance && (line_cnt != LAST_LINE));
  assign rd_addr = cmd.setup ? base_addr_q : base_addr_q + AW'(line_cnt + 1'b1);

  gcp_ram #(
    .WIDTH(8),
    .DEPTH(DEPTH)
  ) u_font (
    .clk    (clk),
    .wr_en  (cmd.capture && !item_mode && load_ok),
    .wr_addr(item_addr + AW'(item_glyph_line)),
    .wr_data(item_glyph_bits),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  always_comb begin
    glyph = in_store_q ? rd_data : 8'h00;
    if (reverse_video) begin
      glyph = ~glyph;
    end
    if (mono_mode && !reverse_video && space_q) begin
      glyph = 8'h00;
    end
    spread = '0;
    for (int k = 0; k < 8; k++) begin
      spread[8*k] = glyph[k];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.advance) begin
      write_offset <= offset_q;
      write_data   <= mono_mode ? {56'd0, glyph} : spread;
      wide_write   <= !mono_mode;
      last_write   <= (line_cnt == LAST_LINE);
    end
  end

  assign status.is_paint  = item_mode;
  assign status.last_line = (line_cnt == LAST_LINE);

endmodule
`default_nettype wire

// ===== rtl/glyph_cell_painter_unit.sv =====
// Glyph cell painter: load beats fill the font store one glyph line byte at a
// time; a paint beat is captured, the setup state then computes the cell's first
// offset with one multiply, and one framebuffer write per glyph line (at most
// fifteen) follows at one per cycle while the write channel does not stall, paced by
// the font store's single read port and the one-write output register. Configuration
// writes are always taken. The font store is not cleared at reset.
// Depends on gcp_pkg, the channel interfaces, gcp_ctrl, gcp_dp and gcp_ram.
`default_nettype none
module glyph_cell_painter_unit #(
  parameter int GLYPH_COUNT = gcp_pkg::GLYPH_COUNT_DEF,
  parameter int GLYPH_LINES = gcp_pkg::GLYPH_LINES_DEF
) (
  input wire logic   clk,
  input wire logic   rst,
  gcp_item_if.sink   items,
  gcp_write_if.source writes,
  gcp_cfg_if.sink    cfg
);

  gcp_pkg::ctrl_cmd_t  cmd;
  gcp_pkg::dp_status_t status;

  assign cfg.ready = 1'b1;

  gcp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (items.valid),
    .in_ready (items.ready),
    .out_valid(writes.valid),
    .out_ready(writes.ready),
    .status   (status),
    .cmd      (cmd)
  );

  gcp_dp #(
    .GLYPH_COUNT(GLYPH_COUNT),
    .GLYPH_LINES(GLYPH_LINES)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .item_mode      (items.mode),
    .item_char_code (items.char_code),
    .item_glyph_line(items.glyph_line),
    .item_glyph_bits(items.glyph_bits),
    .item_text_row  (items.text_row),
    .item_text_col  (items.text_col),
    .cfg_write      (cfg.valid && cfg.ready),
    .cfg_index      (cfg.index),
    .cfg_data       (cfg.data),
    .write_offset   (writes.write_offset),
    .write_data     (writes.write_data),
    .wide_write     (writes.wide_write),
    .last_write     (writes.last_write)
  );

endmodule
`default_nettype wire
